@@ sv/keypad_hold_classifier_assert.svh @@
// assertion macros used by the keypad hold classifier checker
`ifndef KEYPAD_HOLD_CLASSIFIER_ASSERT_SVH
`define KEYPAD_HOLD_CLASSIFIER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define KHC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("keypad hold classifier assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define KHC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("keypad hold classifier assertion failed");

`endif

@@ sv/khc_pkg.sv @@
// shared types and constants of the keypad hold classifier
`timescale 1ns / 1ps

package khc_pkg;

  // default parameter values
  localparam int NUM_KEYS_DEFAULT    = 9;
  localparam int TIMER_WIDTH_DEFAULT = 20;

  // field widths
  localparam int KEY_W    = 6;
  localparam int TICK_W   = 20;
  localparam int SWITCH_W = 4;
  localparam int STATUS_W = 2;
  localparam int REPORT_W = 8;
  localparam int CFG_INDEX_W = 2;

  // report byte layout
  localparam int               REL_BIT     = 6;
  localparam logic [KEY_W-1:0] REPEAT_CODE = 6'h3E;

  // command codes
  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_REPORT = 1'b1;

  // key status codes
  localparam logic [STATUS_W-1:0] STATUS_PRESS  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_SHORT  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_LONG   = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_FAILED = 2'd3;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_HOLD_SHORT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLD_LONG  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_STUCK      = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_TABLE  = 2'd3;

  // register reset values
  localparam logic [TICK_W-1:0] HOLD_SHORT_RESET = 20'd2000;
  localparam logic [TICK_W-1:0] HOLD_LONG_RESET  = 20'd4000;
  localparam logic [TICK_W-1:0] STUCK_RESET      = 20'd20000;

  // one result beat
  typedef struct packed {
    logic                key_event;
    logic [SWITCH_W-1:0] switch_num;
    logic [STATUS_W-1:0] hold_class;
    logic                keypad_failed;
  } result_t;

endpackage

@@ sv/khc_if.sv @@
// valid/ready channel interfaces for input items and result beats
`timescale 1ns / 1ps

interface khc_in_if;
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic [khc_pkg::REPORT_W-1:0] key_report;

  modport source (output valid, output command, output key_report, input ready);
  modport sink   (input valid, input command, input key_report, output ready);
endinterface

interface khc_out_if;
  logic                         valid;
  logic                         ready;
  logic                         key_event;
  logic [khc_pkg::SWITCH_W-1:0] switch_num;
  logic [khc_pkg::STATUS_W-1:0] hold_class;
  logic                         keypad_failed;

  modport source (output valid, output key_event, output switch_num, output hold_class,
                  output keypad_failed, input ready);
  modport sink   (input valid, input key_event, input switch_num, input hold_class,
                  input keypad_failed, output ready);
endinterface

@@ sv/keypad_hold_classifier.sv @@
// keypad hold classifier top level: key release timing, stuck detection, switch lookup
// output: a result beat is registered in the output register, or in the skid register while rsp stalls
// throughput: one input beat per cycle while the skid stage is empty, set by the state update
// an output register plus one skid register keep cmd ready while one result waits
// reset (rst, synchronous): timers, flags, output and skid valid cleared, registers to defaults
`timescale 1ns / 1ps

module keypad_hold_classifier #(
  parameter int NUM_KEYS    = khc_pkg::NUM_KEYS_DEFAULT,
  parameter int TIMER_WIDTH = khc_pkg::TIMER_WIDTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  khc_in_if.sink                          cmd,
  khc_out_if.source                       rsp,
  input  logic                            cfg_we,
  input  logic [khc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [((khc_pkg::TICK_W > khc_pkg::KEY_W * NUM_KEYS) ?
                 khc_pkg::TICK_W : khc_pkg::KEY_W * NUM_KEYS) - 1:0] cfg_data
);

  // key table width and widest compare between a timer and a threshold
  localparam int TABLE_W = khc_pkg::KEY_W * NUM_KEYS;
  localparam int CMP_W   = (TIMER_WIDTH > khc_pkg::TICK_W) ? TIMER_WIDTH : khc_pkg::TICK_W;

  // configuration registers
  logic [khc_pkg::TICK_W-1:0] hold_short_ticks;
  logic [khc_pkg::TICK_W-1:0] hold_long_ticks;
  logic [khc_pkg::TICK_W-1:0] stuck_ticks;
  logic [TABLE_W-1:0]         key_code_table;

  // classifier state
  logic [khc_pkg::KEY_W-1:0]    saved_key,      saved_key_next;
  logic                         press_pending,  press_pending_next;
  logic [TIMER_WIDTH-1:0]       press_elapsed,  press_elapsed_next;
  logic                         repeat_active,  repeat_active_next;
  logic [TIMER_WIDTH-1:0]       repeat_elapsed, repeat_elapsed_next;
  logic [khc_pkg::SWITCH_W-1:0] last_switch,    last_switch_next;
  logic [khc_pkg::STATUS_W-1:0] last_status,    last_status_next;
  logic                         fail_latch,     fail_latch_next;

  // output register and skid stage
  khc_pkg::result_t out_res, skid_res, res;
  logic             out_valid, skid_valid;

  logic                      accept;
  logic [khc_pkg::KEY_W-1:0] key;
  logic                      is_release;
  logic                      event_hit;
  logic [khc_pkg::SWITCH_W-1:0] lookup_id;

  // new input is refused only while the skid stage is full
  assign cmd.ready  = !skid_valid;
  assign accept     = cmd.valid && cmd.ready;
  assign key        = cmd.key_report[khc_pkg::KEY_W-1:0];
  assign is_release = cmd.key_report[khc_pkg::REL_BIT];

  // configuration writes, data masked to each register's width
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_short_ticks <= khc_pkg::HOLD_SHORT_RESET;
      hold_long_ticks  <= khc_pkg::HOLD_LONG_RESET;
      stuck_ticks      <= khc_pkg::STUCK_RESET;
      key_code_table   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        khc_pkg::REG_HOLD_SHORT: hold_short_ticks <= cfg_data[khc_pkg::TICK_W-1:0];
        khc_pkg::REG_HOLD_LONG:  hold_long_ticks  <= cfg_data[khc_pkg::TICK_W-1:0];
        khc_pkg::REG_STUCK:      stuck_ticks      <= cfg_data[khc_pkg::TICK_W-1:0];
        khc_pkg::REG_KEY_TABLE:  key_code_table   <= cfg_data[TABLE_W-1:0];
        default: ;
      endcase
    end
  end

  // switch id lookup: lowest matching table entry wins, 0 if none
  always_comb begin
    lookup_id = '0;
    for (int k = NUM_KEYS - 1; k >= 0; k--) begin
      if (key_code_table[khc_pkg::KEY_W*k +: khc_pkg::KEY_W] == saved_key) begin
        lookup_id = khc_pkg::SWITCH_W'(k + 1);
      end
    end
  end

  // next state for the item on cmd
  always_comb begin
    saved_key_next      = saved_key;
    press_pending_next  = press_pending;
    press_elapsed_next  = press_elapsed;
    repeat_active_next  = repeat_active;
    repeat_elapsed_next = repeat_elapsed;
    last_switch_next    = last_switch;
    last_status_next    = last_status;
    fail_latch_next     = fail_latch;
    event_hit           = 1'b0;

    // a failed keypad freezes everything
    if (!fail_latch) begin
      if (cmd.command == khc_pkg::CMD_TICK) begin
        // saturating timers
        if (press_pending && !(&press_elapsed)) begin
          press_elapsed_next = press_elapsed + TIMER_WIDTH'(1);
        end
        if (repeat_active && !(&repeat_elapsed)) begin
          repeat_elapsed_next = repeat_elapsed + TIMER_WIDTH'(1);
        end
      end else if (!is_release) begin
        if (key == khc_pkg::REPEAT_CODE) begin
          // repeat code keeps the saved key and runs the stuck timer
          if (!repeat_active) begin
            repeat_active_next  = 1'b1;
            repeat_elapsed_next = '0;
          end else if (CMP_W'(repeat_elapsed) >= CMP_W'(stuck_ticks)) begin
            repeat_active_next  = 1'b0;
            repeat_elapsed_next = '0;
            last_status_next    = khc_pkg::STATUS_FAILED;
            fail_latch_next     = 1'b1;
          end
        end else begin
          // ordinary press restarts the hold timer
          saved_key_next      = key;
          press_pending_next  = 1'b1;
          press_elapsed_next  = '0;
          repeat_active_next  = 1'b0;
          repeat_elapsed_next = '0;
        end
      end else if (press_pending && key == saved_key) begin
        // matching release: classify by hold time
        if (CMP_W'(press_elapsed) >= CMP_W'(hold_long_ticks)) begin
          last_status_next = khc_pkg::STATUS_LONG;
        end else if (CMP_W'(press_elapsed) >= CMP_W'(hold_short_ticks)) begin
          last_status_next = khc_pkg::STATUS_SHORT;
        end else begin
          last_status_next = khc_pkg::STATUS_PRESS;
        end
        last_switch_next   = lookup_id;
        press_pending_next = 1'b0;
        press_elapsed_next = '0;
        event_hit          = 1'b1;
      end
    end
  end

  // result beat built from the updated state
  always_comb begin
    res.key_event     = event_hit;
    res.switch_num    = last_switch_next;
    res.hold_class    = last_status_next;
    res.keypad_failed = fail_latch_next;
  end

  // state update on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      saved_key      <= '0;
      press_pending  <= 1'b0;
      press_elapsed  <= '0;
      repeat_active  <= 1'b0;
      repeat_elapsed <= '0;
      last_switch    <= '0;
      last_status    <= khc_pkg::STATUS_PRESS;
      fail_latch     <= 1'b0;
    end else if (accept) begin
      saved_key      <= saved_key_next;
      press_pending  <= press_pending_next;
      press_elapsed  <= press_elapsed_next;
      repeat_active  <= repeat_active_next;
      repeat_elapsed <= repeat_elapsed_next;
      last_switch    <= last_switch_next;
      last_status    <= last_status_next;
      fail_latch     <= fail_latch_next;
    end
  end

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !rsp.ready) begin
      // output stalled: a new result parks in the skid stage
      if (accept) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= accept;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (out_valid && !rsp.ready) begin
      if (accept) begin
        skid_res <= res;
      end
    end else if (skid_valid) begin
      out_res <= skid_res;
    end else if (accept) begin
      out_res <= res;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.key_event     = out_res.key_event;
  assign rsp.switch_num    = out_res.switch_num;
  assign rsp.hold_class    = out_res.hold_class;
  assign rsp.keypad_failed = out_res.keypad_failed;

endmodule

@@ sv/khc_checker.sv @@
// port-level checker for the keypad hold classifier, bound to the top level
`timescale 1ns / 1ps
`include "keypad_hold_classifier_assert.svh"

module khc_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         key_event,
  input logic [khc_pkg::SWITCH_W-1:0] switch_num,
  input logic [khc_pkg::STATUS_W-1:0] hold_class,
  input logic                         keypad_failed
);

  // failed keypad always reports the failed status and no event
  `KHC_ASSERT_NOW(a_fail_status, out_valid && keypad_failed,
                  hold_class == khc_pkg::STATUS_FAILED && !key_event)

  // a classified release never carries the failed status
  `KHC_ASSERT_NOW(a_event_status, out_valid && key_event,
                  hold_class != khc_pkg::STATUS_FAILED && !keypad_failed)

  // stalled beat holds
  `KHC_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready,
                   out_valid && $stable(switch_num) && $stable(hold_class) &&
                   $stable(keypad_failed) && $stable(key_event))

  // fail flag is sticky: a failed beat is followed only by an idle output or another failed beat
  `KHC_ASSERT_NEXT(a_fail_sticky, out_valid && keypad_failed, !out_valid || keypad_failed)

endmodule

bind keypad_hold_classifier khc_checker u_khc_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (rsp.valid),
  .out_ready     (rsp.ready),
  .key_event     (rsp.key_event),
  .switch_num    (rsp.switch_num),
  .hold_class    (rsp.hold_class),
  .keypad_failed (rsp.keypad_failed)
);
